// ===== src/iad_pkg.sv =====
package iad_pkg;

   localparam int DefDataWidth = 32;
   localparam int KindWidth = 8;
   localparam int StatusWidth = 2;

   localparam logic [KindWidth-1:0] KIND_ADD = 8'h2b;
   localparam logic [KindWidth-1:0] KIND_SUB = 8'h2d;
   localparam logic [KindWidth-1:0] KIND_MUL = 8'h2a;
   localparam logic [KindWidth-1:0] KIND_DIV = 8'h2f;
   localparam logic [KindWidth-1:0] KIND_REM = 8'h25;
   localparam logic [KindWidth-1:0] KIND_AND = 8'h26;
   localparam logic [KindWidth-1:0] KIND_OR  = 8'h7c;
   localparam logic [KindWidth-1:0] KIND_NOT = 8'h7e;

   localparam logic [StatusWidth-1:0] STATUS_OK       = 2'd0;
   localparam logic [StatusWidth-1:0] STATUS_DIV_ZERO = 2'd1;
   localparam logic [StatusWidth-1:0] STATUS_BAD_OP   = 2'd2;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_REM = 3'd4,
      OP_AND = 3'd5,
      OP_OR  = 3'd6,
      OP_NOT = 3'd7
   } op_type;

   // Classified request handed from the front to the back.
   typedef struct packed {
      op_type                 op;
      logic [StatusWidth-1:0] status;
   } ctrl_type;

endpackage

// ===== src/iad_front.sv =====
module iad_front #(
   parameter int DATA_WIDTH = iad_pkg::DefDataWidth
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [iad_pkg::KindWidth-1:0] in_kind,
   input  logic [DATA_WIDTH-1:0]        in_a,
   input  logic [DATA_WIDTH-1:0]        in_b,
   output logic                         out_valid,
   input  logic                         out_ready,
   output iad_pkg::ctrl_type            out_ctrl,
   output logic [DATA_WIDTH-1:0]        out_a,
   output logic [DATA_WIDTH-1:0]        out_b
);
   import iad_pkg::*;

   // Two-entry queue decouples classification from execution.
   localparam int Depth = 2;

   ctrl_type             cls;
   ctrl_type             q_ctrl_ff [Depth];
   logic [DATA_WIDTH-1:0] q_a_ff [Depth];
   logic [DATA_WIDTH-1:0] q_b_ff [Depth];
   logic                 wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]           count_ff, count_in;
   logic                 push, pop;

   always_comb begin
      cls.status = STATUS_OK;
      case (in_kind)
         KIND_ADD: cls.op = OP_ADD;
         KIND_SUB: cls.op = OP_SUB;
         KIND_MUL: cls.op = OP_MUL;
         KIND_DIV: cls.op = OP_DIV;
         KIND_REM: cls.op = OP_REM;
         KIND_AND: cls.op = OP_AND;
         KIND_OR:  cls.op = OP_OR;
         KIND_NOT: cls.op = OP_NOT;
         default: begin
            cls.op = OP_ADD;
            cls.status = STATUS_BAD_OP;
         end
      endcase
      if ((cls.op == OP_DIV || cls.op == OP_REM) && in_b == '0) begin
         cls.status = STATUS_DIV_ZERO;
      end
   end

   assign in_ready  = (count_ff != 2'(Depth));
   assign out_valid = (count_ff != 2'd0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_ctrl  = q_ctrl_ff[rd_ptr_ff];
   assign out_a     = q_a_ff[rd_ptr_ff];
   assign out_b     = q_b_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
   assign count_in  = count_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ctrl_ff[wr_ptr_ff] <= cls;
         q_a_ff[wr_ptr_ff]    <= in_a;
         q_b_ff[wr_ptr_ff]    <= in_b;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(Depth)) else $error("front queue overfilled");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'(Depth) |-> !push) else $error("push into full queue");
   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'(Depth)) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with count");

endmodule

// ===== src/iad_back.sv =====
module iad_back #(
   parameter int DATA_WIDTH = iad_pkg::DefDataWidth
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  iad_pkg::ctrl_type              in_ctrl,
   input  logic [DATA_WIDTH-1:0]          in_a,
   input  logic [DATA_WIDTH-1:0]          in_b,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [DATA_WIDTH-1:0]          out_value,
   output logic [iad_pkg::StatusWidth-1:0] out_status
);
   import iad_pkg::*;

   // Stage 0 prepares magnitudes, stages 1..N each retire one quotient bit,
   // then a last stage fixes signs. Other operations ride along.
   localparam int N = DATA_WIDTH;
   localparam int S = N + 2;

   typedef struct packed {
      ctrl_type              ctrl;
      logic                  neg_q;
      logic                  neg_r;
      logic [DATA_WIDTH-1:0] a;
      logic [DATA_WIDTH-1:0] b;
      logic [DATA_WIDTH-1:0] rem;
      logic [DATA_WIDTH-1:0] quo;
      logic [DATA_WIDTH-1:0] res;
   } stage_type;

   stage_type             st_ff [S];
   stage_type             st_in [S];
   logic [S-1:0]          vld_ff;
   logic                  advance;
   logic [DATA_WIDTH-1:0] fast;

   assign advance  = !vld_ff[S-1] || out_ready;
   assign in_ready = advance;

   always_comb begin
      case (in_ctrl.op)
         OP_ADD:  fast = in_a + in_b;
         OP_SUB:  fast = in_a - in_b;
         OP_AND:  fast = in_a & in_b;
         OP_OR:   fast = in_a | in_b;
         OP_NOT:  fast = ~in_a;
         default: fast = '0;
      endcase
   end

   always_comb begin
      st_in[0].ctrl  = in_ctrl;
      st_in[0].neg_q = in_a[N-1] ^ in_b[N-1];
      st_in[0].neg_r = in_a[N-1];
      st_in[0].a     = in_a[N-1] ? -in_a : in_a;
      st_in[0].b     = in_b[N-1] ? -in_b : in_b;
      st_in[0].rem   = '0;
      st_in[0].quo   = '0;
      st_in[0].res   = fast;
      if (in_ctrl.op == OP_MUL) begin
         st_in[0].a = in_a;
         st_in[0].b = in_b;
      end
   end

   genvar g;
   generate
      for (g = 1; g <= N; g++) begin : g_div
         logic [DATA_WIDTH:0] trial;
         logic [DATA_WIDTH:0] sub;
         always_comb begin
            trial = {st_ff[g-1].rem, st_ff[g-1].a[N-g]};
            sub   = trial - {1'b0, st_ff[g-1].b};
            st_in[g] = st_ff[g-1];
            if (!sub[N]) begin
               st_in[g].rem      = sub[N-1:0];
               st_in[g].quo[N-g] = 1'b1;
            end else begin
               st_in[g].rem = trial[N-1:0];
            end
            if (g == 1 && st_ff[0].ctrl.op == OP_MUL) begin
               st_in[g].res = st_ff[0].a * st_ff[0].b;
            end
         end
      end
   endgenerate

   always_comb begin
      st_in[S-1] = st_ff[S-2];
      case (st_ff[S-2].ctrl.op)
         OP_DIV:  st_in[S-1].res = st_ff[S-2].neg_q ? -st_ff[S-2].quo : st_ff[S-2].quo;
         OP_REM:  st_in[S-1].res = st_ff[S-2].neg_r ? -st_ff[S-2].rem : st_ff[S-2].rem;
         default: st_in[S-1].res = st_ff[S-2].res;
      endcase
      if (st_ff[S-2].ctrl.status != STATUS_OK) begin
         st_in[S-1].res = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[S-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st_ff[0] <= st_in[0];
         for (int i = 1; i < S; i++) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   assign out_valid  = vld_ff[S-1];
   assign out_value  = st_ff[S-1].res;
   assign out_status = st_ff[S-1].ctrl.status;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid) else $error("result dropped");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_status != STATUS_OK |-> out_value == '0)
      else $error("error result not zero");
   a_shift: assert property (@(posedge clock) disable iff (reset)
      advance && in_valid |=> vld_ff[0]) else $error("request lost");

endmodule

// ===== src/integer_alu_with_divide.sv =====
// Integer ALU with divide. Requests carry an ASCII operator (+ - * / % & | ~)
// and two signed operands; each returns one value and a status (0 ok,
// 1 divide by zero, 2 unknown operator; value 0 on either error). One
// request is taken per cycle while full is low. Every request passes through
// the pipelined restoring divider that retires one quotient bit per stage;
// all operations travel through the same pipeline so results stay in order.
module integer_alu_with_divide #(
   parameter int DATA_WIDTH = iad_pkg::DefDataWidth
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  logic [iad_pkg::KindWidth-1:0]  req_kind,
   input  logic signed [DATA_WIDTH-1:0]   req_operand_a,
   input  logic signed [DATA_WIDTH-1:0]   req_operand_b,
   output logic                           empty,
   input  logic                           pop,
   output logic signed [DATA_WIDTH-1:0]   rsp_value,
   output logic [iad_pkg::StatusWidth-1:0] rsp_status
);
   import iad_pkg::*;

   logic                  in_ready, mid_valid, mid_ready, out_valid;
   ctrl_type              mid_ctrl;
   logic [DATA_WIDTH-1:0] mid_a, mid_b, value;

   iad_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
      .clock, .reset,
      .in_valid(push), .in_ready(in_ready), .in_kind(req_kind),
      .in_a(req_operand_a), .in_b(req_operand_b),
      .out_valid(mid_valid), .out_ready(mid_ready), .out_ctrl(mid_ctrl),
      .out_a(mid_a), .out_b(mid_b)
   );

   iad_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
      .clock, .reset,
      .in_valid(mid_valid), .in_ready(mid_ready), .in_ctrl(mid_ctrl),
      .in_a(mid_a), .in_b(mid_b),
      .out_valid(out_valid), .out_ready(pop), .out_value(value),
      .out_status(rsp_status)
   );

   assign full      = !in_ready;
   assign empty     = !out_valid;
   assign rsp_value = value;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> empty && !full) else $error("not clear after reset");
   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      !empty |-> rsp_status <= STATUS_BAD_OP) else $error("illegal status");
   a_pop_stable: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_value))
      else $error("result changed while waiting");

endmodule
